>>> rtl/core/aarm_pkg.sv
package aarm_pkg;

  // Arctangent table, binary angle with pi = 2^31
  localparam int AtanLen = 24;
  localparam logic [31:0] ATAN_TABLE [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // CORDIC start value, gain reciprocal in Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [16:0] Q14_ONE = 17'sd16384;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row2_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row2_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col2;
  } out_item_t;

endpackage

>>> rtl/core/aarm_in_if.sv
interface aarm_in_if;
  logic valid;
  logic ready;
  aarm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/aarm_out_if.sv
interface aarm_out_if;
  logic valid;
  logic ready;
  aarm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/axis_angle_rotation_matrix_core.sv
// Channel | Dir | Payload
// in_     | in  | axis_x, axis_y, axis_z (Q2.14), angle (pi = 32768)
// out_    | out | m_rowR_colC, nine entries, Q2.14 saturated
//
// The pipeline is one fold stage, one register per CORDIC iteration (CORDIC_STEPS,
// capped at AtanLen), then round, product, scale and sum stages.
// One item per cycle sustained; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Synchronous active-low reset clears the valid bits only.
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst_n,
  aarm_in_if.sink in_ch,
  aarm_out_if.source out_ch
);
  import aarm_pkg::*;

  localparam int NS = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
  localparam int NST = NS + 5;

  logic adv;
  logic [NST-1:0] vld_r;

  assign adv = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // CORDIC pipeline; ax/ay/az ride along
  logic signed [33:0] x_r [NS+1];
  logic signed [33:0] y_r [NS+1];
  logic signed [32:0] z_r [NS+1];
  logic flip_r [NS+1];
  logic signed [15:0] ax_r [NS+1];
  logic signed [15:0] ay_r [NS+1];
  logic signed [15:0] az_r [NS+1];

  // fold stage
  logic signed [32:0] z0;
  always_comb begin
    z0 = {in_ch.data.angle[15], in_ch.data.angle, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      ax_r[0] <= in_ch.data.axis_x;
      ay_r[0] <= in_ch.data.axis_y;
      az_r[0] <= in_ch.data.axis_z;
      if (z0 > 33'sd1073741824) begin
        z_r[0] <= z0 - 33'sd2147483648;
        flip_r[0] <= 1'b1;
      end else if (z0 < -33'sd1073741824) begin
        z_r[0] <= z0 + 33'sd2147483648;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = {1'b0, ATAN_TABLE[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
        flip_r[i+1] <= flip_r[i];
        ax_r[i+1] <= ax_r[i];
        ay_r[i+1] <= ay_r[i];
        az_r[i+1] <= az_r[i];
      end
    end
  end

  // round to Q2.14 and undo the fold
  logic signed [33:0] xr, yr;
  logic signed [17:0] c_r, s_r;
  logic signed [15:0] bx_r, by_r, bz_r;
  assign xr = (x_r[NS] + 34'sd32768) >>> 16;
  assign yr = (y_r[NS] + 34'sd32768) >>> 16;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= flip_r[NS] ? -xr[17:0] : xr[17:0];
      s_r <= flip_r[NS] ? -yr[17:0] : yr[17:0];
      bx_r <= ax_r[NS];
      by_r <= ay_r[NS];
      bz_r <= az_r[NS];
    end
  end

  // axis products, sin terms, 1 - cos
  logic signed [31:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic signed [33:0] sx_r, sy_r, sz_r;
  logic signed [18:0] omc_r;
  logic signed [17:0] c2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx_r <= bx_r * bx_r;
      pyy_r <= by_r * by_r;
      pzz_r <= bz_r * bz_r;
      pxy_r <= bx_r * by_r;
      pxz_r <= bx_r * bz_r;
      pyz_r <= by_r * bz_r;
      sx_r <= bx_r * s_r;
      sy_r <= by_r * s_r;
      sz_r <= bz_r * s_r;
      omc_r <= 19'(Q14_ONE) - 19'(c_r);
      c2_r <= c_r;
    end
  end

  // scale by 1 - cos
  logic signed [50:0] t_r [6];
  logic signed [33:0] sx2_r, sy2_r, sz2_r;
  logic signed [17:0] c3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= pxx_r * omc_r;
      t_r[1] <= pyy_r * omc_r;
      t_r[2] <= pzz_r * omc_r;
      t_r[3] <= pxy_r * omc_r;
      t_r[4] <= pxz_r * omc_r;
      t_r[5] <= pyz_r * omc_r;
      sx2_r <= sx_r;
      sy2_r <= sy_r;
      sz2_r <= sz_r;
      c3_r <= c2_r;
    end
  end

  function automatic logic signed [15:0] pack_q14(input logic signed [52:0] v);
    logic signed [52:0] r;
    r = (v + 53'sd134217728) >>> 28;
    if (r > 53'sd32767) return 16'sd32767;
    if (r < -53'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  // sum, round, saturate into the output register
  logic signed [52:0] cd, wx, wy, wz;
  assign cd = 53'(c3_r) <<< 28;
  assign wx = 53'(sx2_r) <<< 14;
  assign wy = 53'(sy2_r) <<< 14;
  assign wz = 53'(sz2_r) <<< 14;

  out_item_t o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.m_row0_col0 <= pack_q14(53'(t_r[0]) + cd);
      o_r.m_row1_col0 <= pack_q14(53'(t_r[3]) + wz);
      o_r.m_row2_col0 <= pack_q14(53'(t_r[4]) - wy);
      o_r.m_row0_col1 <= pack_q14(53'(t_r[3]) - wz);
      o_r.m_row1_col1 <= pack_q14(53'(t_r[1]) + cd);
      o_r.m_row2_col1 <= pack_q14(53'(t_r[5]) + wx);
      o_r.m_row0_col2 <= pack_q14(53'(t_r[4]) + wy);
      o_r.m_row1_col2 <= pack_q14(53'(t_r[5]) - wx);
      o_r.m_row2_col2 <= pack_q14(53'(t_r[2]) + cd);
    end
  end

  assign out_ch.valid = vld_r[NST-1];
  assign out_ch.data = o_r;

endmodule
